// File: rtl/core/mfq_pkg.sv
// Package for the multilevel priority FIFO queue.
// Holds the request and response types, operation and status codes, sequencer states
// and parameter defaults. It has no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mfq_pkg;

	localparam int CAPACITY_DEF = 64;
	localparam int LEVELS_DEF   = 16;
	localparam int TAG_BITS_DEF = 32;

	localparam logic [2:0] FN_PUSH      = 3'd0;
	localparam logic [2:0] FN_POP       = 3'd1;
	localparam logic [2:0] FN_REMOVE    = 3'd2;
	localparam logic [2:0] FN_REMOVE_LV = 3'd3;
	localparam logic [2:0] FN_PEEK      = 3'd4;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_EMPTY    = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;
	localparam logic [1:0] ST_BAD_LVL  = 2'd3;

	typedef struct packed {
		logic [2:0]  func;
		logic [31:0] data_tag;
		logic [3:0]  level;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] data_out;
		logic [6:0]  item_total;
	} rsp_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_PUSH_WR,
		S_PUSH_LINK,
		S_POP_WR,
		S_WALK_LVL,
		S_WALK_CMP,
		S_UNLINK_FREE,
		S_DONE
	} state_t;

endpackage

`default_nettype wire

// File: rtl/core/mfq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module mfq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// File: rtl/core/multilevel_priority_fifo_queue.sv
// Top level of the multilevel priority FIFO queue: sequencer, level tables and free list.
// Depends on mfq_pkg and mfq_ram.
//
// Usage: a request on in_req (valid/ready) carries an operation, a tag and a level.
// Push appends the tag at its level, pop and peek return the oldest item of the
// lowest non-empty level, and remove deletes the first item in service order whose
// tag matches, in any level or in one level. Each request yields exactly one response
// on out_rsp (valid/ready) with status, data and the number of items held.
// The cfg channel writes top_level, the highest level that push and level remove accept.
// Push adds a link step when its level already holds items. Remove visits the levels
// in turn, compares the items one by one and frees a matched item in a further step, as
// the list walk reads one slot per cycle through the read port.
// One request is worked on at a time; in_ready is high only while the sequencer idles.
// A finished response waits in an output register, so a stalled receiver holds back
// only the completion of the following request.
// Reset empties every level and rebuilds the free list at once; no clearing pass runs.
`timescale 1ns / 1ps
`default_nettype none

module multilevel_priority_fifo_queue import mfq_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF,
	parameter int LEVELS   = LEVELS_DEF,
	parameter int TAG_BITS = TAG_BITS_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire req_t       in_req,
	output logic            out_valid,
	input  wire logic       out_ready,
	output rsp_t            out_rsp,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [3:0] cfg_data
);

	localparam int AW = $clog2(CAPACITY);
	localparam int PW = $clog2(CAPACITY + 1);
	localparam int LW = $clog2(LEVELS);
	localparam int TW = (TAG_BITS < 32) ? TAG_BITS : 32;
	localparam logic [PW-1:0] NIL = PW'(CAPACITY);
	localparam logic [LW-1:0] LAST_LVL = LW'(LEVELS - 1);

	state_t state_q, state_d;

	logic [3:0]    top_q;
	logic [PW-1:0] head_q [LEVELS];
	logic [PW-1:0] tail_q [LEVELS];
	logic [PW-1:0] free_head_q;
	logic [PW-1:0] wm_q;
	logic [PW-1:0] count_q;
	logic [2:0]    op_q;
	logic [TW-1:0] tag_q;
	logic [LW-1:0] lvl_q;
	logic [PW-1:0] cur_q;
	logic [PW-1:0] prev_q;
	logic          fresh_q;
	logic [1:0]    status_q;
	logic [TW-1:0] data_q;
	logic          out_valid_q;
	rsp_t          out_q;

	logic          tag_we, link_we;
	logic [AW-1:0] raddr, link_waddr;
	logic [PW-1:0] link_wdata;
	logic [TW-1:0] tag_rdata;
	logic [PW-1:0] link_rdata;
	logic [PW-1:0] link_val;

	logic          accept;
	logic          lv_bad;
	logic [LW-1:0] in_lvl;
	logic [TW-1:0] in_tag;
	logic          any_ne;
	logic [LW-1:0] first_lvl;
	logic [LEVELS-1:0] head_ne, tail_ne;
	logic          tag_hit;
	logic          last_lvl;
	logic          out_free;

	mfq_ram #(.WIDTH(TW), .DEPTH(CAPACITY)) u_tag_ram (
		.clk   (clk),
		.we    (tag_we),
		.waddr (cur_q[AW-1:0]),
		.wdata (tag_q),
		.raddr (raddr),
		.rdata (tag_rdata)
	);

	mfq_ram #(.WIDTH(PW), .DEPTH(CAPACITY)) u_link_ram (
		.clk   (clk),
		.we    (link_we),
		.waddr (link_waddr),
		.wdata (link_wdata),
		.raddr (raddr),
		.rdata (link_rdata)
	);

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_rsp   = out_q;
	assign out_free  = !out_valid_q || out_ready;

	assign in_lvl  = LW'(in_req.level);
	assign in_tag  = in_req.data_tag[TW-1:0];
	assign lv_bad  = (in_req.level > top_q) || (32'(in_req.level) >= 32'(LEVELS));
	assign tag_hit = (tag_rdata == tag_q);
	assign last_lvl = (lvl_q == LAST_LVL);
	assign link_val = fresh_q ? PW'(cur_q + 1'b1) : link_rdata;

	always_comb begin
		any_ne    = 1'b0;
		first_lvl = '0;
		for (int i = 0; i < LEVELS; i++) begin
			head_ne[i] = (head_q[i] != NIL);
			tail_ne[i] = (tail_q[i] != NIL);
			if (!any_ne && head_ne[i]) begin
				any_ne    = 1'b1;
				first_lvl = LW'(i);
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					priority if (in_req.func == FN_PUSH) begin
						state_d = (lv_bad || count_q == PW'(CAPACITY)) ? S_DONE : S_PUSH_WR;
					end else if (in_req.func == FN_POP || in_req.func == FN_PEEK) begin
						state_d = any_ne ? S_POP_WR : S_DONE;
					end else if (in_req.func == FN_REMOVE) begin
						state_d = S_WALK_LVL;
					end else if (in_req.func == FN_REMOVE_LV) begin
						state_d = lv_bad ? S_DONE : S_WALK_LVL;
					end else begin
						state_d = S_DONE;
					end
				end
			end
			S_PUSH_WR:     state_d = (tail_q[lvl_q] != NIL) ? S_PUSH_LINK : S_DONE;
			S_PUSH_LINK:   state_d = S_DONE;
			S_POP_WR:      state_d = S_DONE;
			S_WALK_LVL: begin
				if (head_q[lvl_q] != NIL) begin
					state_d = S_WALK_CMP;
				end else if (!(op_q == FN_REMOVE && !last_lvl)) begin
					state_d = S_DONE;
				end
			end
			S_WALK_CMP: begin
				priority if (tag_hit) begin
					state_d = S_UNLINK_FREE;
				end else if (link_rdata != NIL) begin
					state_d = S_WALK_CMP;
				end else if (op_q == FN_REMOVE && !last_lvl) begin
					state_d = S_WALK_LVL;
				end else begin
					state_d = S_DONE;
				end
			end
			S_UNLINK_FREE: state_d = S_DONE;
			S_DONE:        state_d = out_free ? S_IDLE : S_DONE;
			default:       state_d = S_IDLE;
		endcase
	end

	always_comb begin
		tag_we     = 1'b0;
		link_we    = 1'b0;
		link_waddr = cur_q[AW-1:0];
		link_wdata = NIL;
		raddr      = cur_q[AW-1:0];
		unique case (state_q)
			S_IDLE: begin
				raddr = (in_req.func == FN_PUSH) ? free_head_q[AW-1:0]
				                                 : head_q[first_lvl][AW-1:0];
			end
			S_PUSH_WR: begin
				tag_we  = 1'b1;
				link_we = 1'b1;
			end
			S_PUSH_LINK: begin
				link_we    = 1'b1;
				link_waddr = tail_q[lvl_q][AW-1:0];
				link_wdata = cur_q;
			end
			S_POP_WR: begin
				link_we    = (op_q == FN_POP);
				link_wdata = free_head_q;
			end
			S_WALK_LVL: begin
				raddr = head_q[lvl_q][AW-1:0];
			end
			S_WALK_CMP: begin
				raddr      = link_rdata[AW-1:0];
				link_we    = tag_hit && (prev_q != NIL);
				link_waddr = prev_q[AW-1:0];
				link_wdata = link_rdata;
			end
			S_UNLINK_FREE: begin
				link_we    = 1'b1;
				link_wdata = free_head_q;
			end
			S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			top_q       <= 4'd15;
			free_head_q <= '0;
			wm_q        <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < LEVELS; i++) begin
				head_q[i] <= NIL;
				tail_q[i] <= NIL;
			end
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				top_q <= cfg_data;
			end
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
				end
				S_PUSH_WR: begin
					free_head_q <= link_val;
					if (cur_q == wm_q) begin
						wm_q <= PW'(wm_q + 1'b1);
					end
					if (tail_q[lvl_q] == NIL) begin
						head_q[lvl_q] <= cur_q;
						tail_q[lvl_q] <= cur_q;
						count_q       <= PW'(count_q + 1'b1);
					end
				end
				S_PUSH_LINK: begin
					tail_q[lvl_q] <= cur_q;
					count_q       <= PW'(count_q + 1'b1);
				end
				S_POP_WR: begin
					if (op_q == FN_POP) begin
						head_q[lvl_q] <= link_rdata;
						if (tail_q[lvl_q] == cur_q) begin
							tail_q[lvl_q] <= NIL;
						end
						free_head_q <= cur_q;
						count_q     <= PW'(count_q - 1'b1);
					end
				end
				S_WALK_CMP: begin
					if (tag_hit) begin
						if (prev_q == NIL) begin
							head_q[lvl_q] <= link_rdata;
						end
						if (tail_q[lvl_q] == cur_q) begin
							tail_q[lvl_q] <= prev_q;
						end
						count_q <= PW'(count_q - 1'b1);
					end
				end
				S_UNLINK_FREE: begin
					free_head_q <= cur_q;
				end
				S_DONE: begin
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					op_q   <= in_req.func;
					tag_q  <= in_tag;
					data_q <= '0;
					if (in_req.func == FN_POP || in_req.func == FN_PEEK) begin
						lvl_q    <= first_lvl;
						cur_q    <= head_q[first_lvl];
						fresh_q  <= 1'b0;
						status_q <= any_ne ? ST_OK : ST_EMPTY;
					end else begin
						lvl_q   <= (in_req.func == FN_REMOVE) ? '0 : in_lvl;
						cur_q   <= free_head_q;
						fresh_q <= (free_head_q >= wm_q);
						priority if (in_req.func == FN_PUSH && lv_bad) begin
							status_q <= ST_BAD_LVL;
						end else if (in_req.func == FN_PUSH && count_q == PW'(CAPACITY)) begin
							status_q <= ST_FULL;
						end else if (in_req.func == FN_REMOVE_LV && lv_bad) begin
							status_q <= ST_BAD_LVL;
						end else begin
							status_q <= ST_OK;
						end
					end
				end
			end
			S_POP_WR: begin
				data_q <= tag_rdata;
			end
			S_WALK_LVL: begin
				prev_q  <= NIL;
				cur_q   <= head_q[lvl_q];
				fresh_q <= 1'b0;
				if (head_q[lvl_q] == NIL) begin
					if (op_q == FN_REMOVE && !last_lvl) begin
						lvl_q <= LW'(lvl_q + 1'b1);
					end else begin
						status_q <= ST_EMPTY;
					end
				end
			end
			S_WALK_CMP: begin
				if (!tag_hit) begin
					prev_q <= cur_q;
					cur_q  <= link_rdata;
					if (link_rdata == NIL) begin
						if (op_q == FN_REMOVE && !last_lvl) begin
							lvl_q <= LW'(lvl_q + 1'b1);
						end else begin
							status_q <= ST_EMPTY;
						end
					end
				end
			end
			S_DONE: begin
				if (out_free) begin
					out_q.status     <= status_q;
					out_q.data_out   <= 32'(data_q);
					out_q.item_total <= 7'(count_q);
				end
			end
			default: begin
			end
		endcase
	end

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= PW'(CAPACITY))
		else $error("Held count exceeds the capacity.");

	a_empty_levels: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) == (head_ne == '0))
		else $error("Held count disagrees with the level heads.");

	a_head_tail: assert property (@(posedge clk) disable iff (!arst_n)
		head_ne == tail_ne)
		else $error("A level has a head without a tail or the reverse.");

	a_free_list: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> ((free_head_q == NIL) == (count_q == PW'(CAPACITY))))
		else $error("Free list state disagrees with the held count.");
`endif

endmodule

`default_nettype wire
